>>> sv/sdf_pkg.sv
// Shared types and constants for the signed decimal field formatter.
// No dependencies; every other file refers to it by scoped names.
package sdf_pkg;

    localparam int DIGITS_DEF     = 10;
    localparam int VALUE_BITS_DEF = 32;
    localparam int LINE_COLUMNS   = 16;
    localparam int MAX_RESULTS    = 12;
    localparam int CNT_W          = 4;
    // magnitude bits consumed per cycle by the digit row
    localparam int STEP_BITS      = 3;

    localparam logic [4:0] ADJ_CORR   = 5'h06;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;

    typedef logic [3:0] t_bcd;

    typedef struct packed {
        logic       neg;
        logic [3:0] first;
        logic       has_p;
        logic [3:0] pidx;
    } t_fmt_ctrl;

    typedef enum logic [2:0] {
        E_IDLE,
        E_SKIP,
        E_MINUS,
        E_DIGIT,
        E_POINT
    } t_emit_state;

endpackage

>>> sv/sdf_if.sv
// Valid/ready channels of the formatter: value in, character writes out.
// Depends on sdf_pkg for the default value width.
interface sdf_in_if #(
    parameter int VALUE_BITS = sdf_pkg::VALUE_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic [3:0]                   start_column;
    logic [3:0]                   point_column;

    modport source (output valid, value, start_column, point_column, input ready);
    modport sink   (input valid, value, start_column, point_column, output ready);
endinterface

interface sdf_out_if ();
    logic       valid;
    logic       ready;
    logic [3:0] position;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, position, char_code, last, input ready);
    modport sink   (input valid, position, char_code, last, output ready);
endinterface

>>> sv/sdf_cell.sv
// One BCD digit cell of the double-dabble row: shift in STEP_BITS bits per enabled cycle,
// add the correction and hand the carries to the next more significant cell.
// Depends on sdf_pkg.
module sdf_cell (
    input  logic                             i_clk,
    input  logic                             i_clear,
    input  logic                             i_en,
    input  logic [sdf_pkg::STEP_BITS-1:0]    i_cin,
    output logic [sdf_pkg::STEP_BITS-1:0]    o_cout,
    output sdf_pkg::t_bcd                    o_digit
);

    sdf_pkg::t_bcd r_digit;
    sdf_pkg::t_bcd n_digit;

    // carry out depends only on the digit before the shift: 2*d+c > 9 iff d >= 5
    always_comb begin
        sdf_pkg::t_bcd d;
        logic [4:0]    t;
        d = r_digit;
        t = '0;
        for (int j = sdf_pkg::STEP_BITS - 1; j >= 0; j--) begin
            o_cout[j] = (d >= 4'd5);
            t = {d, i_cin[j]};
            if (d >= 4'd5) begin
                t = t + sdf_pkg::ADJ_CORR;
            end
            d = t[3:0];
        end
        n_digit = d;
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digit <= '0;
        end else if (i_en) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

>>> sv/sdf_conv.sv
// Converter: takes a value, forms its magnitude and runs it through a row of
// digit cells STEP_BITS bits per cycle. Depends on sdf_pkg, sdf_if and sdf_cell.
module sdf_conv #(
    parameter int DIGITS     = sdf_pkg::DIGITS_DEF,
    parameter int VALUE_BITS = sdf_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sdf_in_if.sink                          i_in,
    input  logic                            i_take,
    output logic                            o_valid,
    output logic                            o_busy,
    output sdf_pkg::t_bcd [DIGITS-1:0]      o_digits,
    output sdf_pkg::t_fmt_ctrl              o_ctrl
);

    localparam int STEP      = sdf_pkg::STEP_BITS;
    localparam int STEPS     = (VALUE_BITS + STEP - 1) / STEP;
    localparam int PAD_BITS  = STEPS * STEP;
    localparam int SC_W      = $clog2(STEPS);
    localparam int FIRST_MAX = ((DIGITS > 15) ? 15 : DIGITS) - 1;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [SC_W-1:0]       r_step, n_step;
    logic [PAD_BITS-1:0]   r_mag,  n_mag;
    sdf_pkg::t_fmt_ctrl    r_ctrl, n_ctrl;

    logic                  w_accept;
    logic [VALUE_BITS-1:0] w_mag;
    sdf_pkg::t_fmt_ctrl    w_ctrl;
    logic [STEP-1:0]       w_carry [DIGITS+1];

    assign i_in.ready = !r_busy && (!r_done || i_take);
    assign w_accept   = i_in.valid && i_in.ready;

    // two's complement magnitude; the most negative value maps onto itself unsigned
    assign w_mag = i_in.value[VALUE_BITS-1] ? (~$unsigned(i_in.value) + 1'b1)
                                            : $unsigned(i_in.value);

    always_comb begin
        w_ctrl.neg = i_in.value[VALUE_BITS-1];
        if (i_in.start_column == 4'd0) begin
            w_ctrl.first = 4'd0;
        end else if (int'(i_in.start_column) > DIGITS) begin
            w_ctrl.first = 4'(FIRST_MAX);
        end else begin
            w_ctrl.first = i_in.start_column - 4'd1;
        end
        w_ctrl.has_p = (i_in.point_column != 4'd0) && (int'(i_in.point_column) <= DIGITS);
        w_ctrl.pidx  = i_in.point_column - 4'd1;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_step = r_step;
        n_mag  = r_mag;
        n_ctrl = r_ctrl;
        if (r_done && i_take) begin
            n_done = 1'b0;
        end
        if (r_busy) begin
            n_mag  = r_mag << STEP;
            n_step = r_step + 1'b1;
            if (r_step == SC_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = '0;
            n_mag  = PAD_BITS'(w_mag);
            n_ctrl = w_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_ctrl <= n_ctrl;
    end

    // least significant cell takes the magnitude bits, MSB first
    assign w_carry[DIGITS] = r_mag[PAD_BITS-1 -: STEP];

    for (genvar k = 0; k < DIGITS; k++) begin : g_cell
        sdf_cell u_cell (
            .i_clk   (i_clk),
            .i_clear (w_accept),
            .i_en    (r_busy),
            .i_cin   (w_carry[k+1]),
            .o_cout  (w_carry[k]),
            .o_digit (o_digits[k])
        );
    end

    assign o_valid = r_done;
    assign o_busy  = r_busy;
    assign o_ctrl  = r_ctrl;

endmodule

>>> sv/sdf_emit.sv
// Emitter: walks the digit row one place at a time and writes the characters
// of the field through a registered output stage. Depends on sdf_pkg, sdf_if.
module sdf_emit #(
    parameter int DIGITS = sdf_pkg::DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  sdf_pkg::t_bcd [DIGITS-1:0]  i_digits,
    input  sdf_pkg::t_fmt_ctrl          i_ctrl,
    sdf_out_if.source                   o_out
);

    localparam int IDX_W = $clog2(DIGITS + 1);
    localparam int COL_W = $clog2(sdf_pkg::LINE_COLUMNS + DIGITS);
    localparam int CNT_W = sdf_pkg::CNT_W;

    sdf_pkg::t_emit_state          r_state, n_state;
    sdf_pkg::t_bcd [DIGITS-1:0]    r_dig,   n_dig;
    logic [IDX_W-1:0]              r_idx,   n_idx;
    logic [COL_W-1:0]              r_col,   n_col;
    logic [CNT_W-1:0]              r_cnt,   n_cnt;
    logic                          r_over,  n_over;
    logic                          r_blank, n_blank;
    sdf_pkg::t_fmt_ctrl            r_ctrl,  n_ctrl;

    logic                          r_ov;
    logic [3:0]                    r_pos;
    logic [7:0]                    r_char;
    logic                          r_last;

    logic                          w_adv, w_load, w_emit, w_last, w_shift;
    logic [COL_W-1:0]              w_pos_full, w_col_inc, w_nextpos;
    logic [7:0]                    w_char;
    logic [IDX_W-1:0]              w_idx_inc;
    sdf_pkg::t_bcd                 w_head, w_nxt;
    logic                          w_is_pt, w_nxt_pt, w_pt0, w_at_end;
    logic                          w_blank_after, w_nd_minus, w_cap;
    logic                          w_go_point, w_has_next;

    function automatic logic minus_due(input logic over, input logic neg, input logic blank,
                                       input sdf_pkg::t_bcd digit, input logic pt);
        return !over && neg && blank && ((digit != 4'd0) || pt);
    endfunction

    assign w_adv     = !r_ov || o_out.ready;
    assign w_head    = r_dig[0];
    assign w_nxt     = r_dig[1];
    assign w_idx_inc = r_idx + 1'b1;
    assign w_col_inc = r_col + 1'b1;
    assign w_is_pt   = r_ctrl.has_p && (r_idx == IDX_W'(r_ctrl.pidx));
    assign w_nxt_pt  = r_ctrl.has_p && (w_idx_inc == IDX_W'(r_ctrl.pidx));
    assign w_pt0     = i_ctrl.has_p && (i_ctrl.pidx == 4'd0);
    assign w_at_end  = (w_idx_inc == IDX_W'(DIGITS));
    assign w_cap     = (r_cnt == CNT_W'(sdf_pkg::MAX_RESULTS - 1));
    // the point digit is always shown, so this is low while on the point
    assign w_blank_after = r_blank && !((w_head != 4'd0) || w_is_pt);
    assign w_nd_minus    = minus_due(r_over, r_ctrl.neg, w_blank_after, w_nxt, w_nxt_pt);

    assign o_ready = (r_state == sdf_pkg::E_IDLE) || (w_emit && w_adv && w_last);
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        n_dig      = r_dig;
        n_idx      = r_idx;
        n_col      = r_col;
        n_cnt      = r_cnt;
        n_over     = r_over;
        n_blank    = r_blank;
        n_ctrl     = r_ctrl;
        w_emit     = 1'b0;
        w_pos_full = r_col;
        w_char     = sdf_pkg::CH_SPACE;
        w_last     = 1'b0;
        w_shift    = 1'b0;
        w_go_point = 1'b0;
        w_has_next = 1'b0;
        w_nextpos  = w_col_inc;

        case (r_state)
            sdf_pkg::E_SKIP: begin
                // collect overflow from the digits in front of the field
                w_shift = 1'b1;
                n_idx   = w_idx_inc;
                n_over  = r_over | (w_head != 4'd0);
                if (w_idx_inc == IDX_W'(r_ctrl.first)) begin
                    n_state = minus_due(n_over, r_ctrl.neg, 1'b1, w_nxt, w_nxt_pt)
                              ? sdf_pkg::E_MINUS : sdf_pkg::E_DIGIT;
                end
            end
            sdf_pkg::E_MINUS: begin
                w_emit     = 1'b1;
                w_pos_full = r_col - 1'b1;
                w_char     = sdf_pkg::CH_MINUS;
                w_last     = w_cap || (r_col >= COL_W'(sdf_pkg::LINE_COLUMNS));
                if (w_adv) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = w_last ? sdf_pkg::E_IDLE : sdf_pkg::E_DIGIT;
                end
            end
            sdf_pkg::E_DIGIT, sdf_pkg::E_POINT: begin
                w_emit = 1'b1;
                if (r_state == sdf_pkg::E_POINT) begin
                    w_char = sdf_pkg::CH_POINT;
                end else if (r_over) begin
                    w_char = sdf_pkg::CH_MINUS;
                end else if (w_blank_after) begin
                    w_char = sdf_pkg::CH_SPACE;
                end else begin
                    w_char = sdf_pkg::ASCII_ZERO + {4'h0, w_head};
                end
                w_go_point = (r_state == sdf_pkg::E_DIGIT) && w_is_pt;
                if (w_go_point) begin
                    w_has_next = 1'b1;
                    w_nextpos  = w_col_inc;
                end else begin
                    w_has_next = !w_at_end;
                    w_nextpos  = w_nd_minus ? r_col : w_col_inc;
                end
                // writes past the line end are dropped, so stop at the last one that fits
                w_last = w_cap || !w_has_next
                         || (w_nextpos >= COL_W'(sdf_pkg::LINE_COLUMNS));
                if (w_adv) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_col   = w_col_inc;
                    n_blank = w_blank_after;
                    if (w_last) begin
                        n_state = sdf_pkg::E_IDLE;
                    end else if (w_go_point) begin
                        n_state = sdf_pkg::E_POINT;
                    end else begin
                        w_shift = 1'b1;
                        n_idx   = w_idx_inc;
                        n_state = w_nd_minus ? sdf_pkg::E_MINUS : sdf_pkg::E_DIGIT;
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_shift) begin
            n_dig = r_dig >> 4;
        end

        if (w_load) begin
            n_dig   = i_digits;
            n_idx   = '0;
            n_col   = COL_W'(i_ctrl.first) + 1'b1;
            n_cnt   = '0;
            n_over  = 1'b0;
            n_blank = 1'b1;
            n_ctrl  = i_ctrl;
            if (i_ctrl.first == 4'd0) begin
                n_state = minus_due(1'b0, i_ctrl.neg, 1'b1, i_digits[0], w_pt0)
                          ? sdf_pkg::E_MINUS : sdf_pkg::E_DIGIT;
            end else begin
                n_state = sdf_pkg::E_SKIP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdf_pkg::E_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_ov <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig   <= n_dig;
        r_idx   <= n_idx;
        r_col   <= n_col;
        r_cnt   <= n_cnt;
        r_over  <= n_over;
        r_blank <= n_blank;
        r_ctrl  <= n_ctrl;
        if (w_adv) begin
            r_pos  <= w_pos_full[3:0];
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.position  = r_pos;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

endmodule

>>> sv/signed_decimal_field_formatter.sv
// Conversion runs the magnitude through the digit row, then the emitter skips start_column-1
// places and writes one character per cycle while the output channel is not stalled.
// The digit row and the emitter overlap, so a value converts while the previous one writes.
// Reset: synchronous, active low; clears the handshake and sequencing state only.
// Depends on sdf_pkg, sdf_if, sdf_cell, sdf_conv and sdf_emit.
module signed_decimal_field_formatter #(
    parameter int DIGITS     = sdf_pkg::DIGITS_DEF,
    parameter int VALUE_BITS = sdf_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdf_in_if.sink     i_in,
    sdf_out_if.source  o_out
);

    logic                        w_conv_valid;
    logic                        w_conv_busy;
    logic                        w_emit_ready;
    logic                        w_take;
    sdf_pkg::t_bcd [DIGITS-1:0]  w_digits;
    sdf_pkg::t_fmt_ctrl          w_ctrl;

    assign w_take = w_conv_valid && w_emit_ready;

    sdf_conv #(
        .DIGITS     (DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_take   (w_take),
        .o_valid  (w_conv_valid),
        .o_busy   (w_conv_busy),
        .o_digits (w_digits),
        .o_ctrl   (w_ctrl)
    );

    sdf_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_conv_valid),
        .o_ready  (w_emit_ready),
        .i_digits (w_digits),
        .i_ctrl   (w_ctrl),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    // an accepted value must start the digit row
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> w_conv_busy)
        else $error("digit row idle after a value transfer");

    // no new value may enter while the row is still shifting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_busy |-> !i_in.ready)
        else $error("input ready while conversion in progress");

    // only spaces, digits, minus and point are ever written
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.char_code == sdf_pkg::CH_SPACE)
                      || (o_out.char_code == sdf_pkg::CH_MINUS)
                      || (o_out.char_code == sdf_pkg::CH_POINT)
                      || ((o_out.char_code >= sdf_pkg::ASCII_ZERO)
                          && (o_out.char_code <= sdf_pkg::ASCII_ZERO + 8'd9))))
        else $error("unexpected character code");
`endif

endmodule
